>>> hdl/bres_pkg.sv
// Shared widths, codes and types of the line rasterizer.
package bres_pkg;

   localparam int COORD_BITS     = 12;
   localparam int DELTA_BITS     = COORD_BITS + 1;
   localparam int ERR_BITS       = COORD_BITS + 2;
   localparam int COLOR_BITS     = 16;
   localparam int SCREEN_BITS    = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 8'd160;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 8'd128;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] sdelta_type;
   typedef logic        [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic        [COLOR_BITS-1:0] color_type;
   typedef logic        [SCREEN_BITS-1:0] screen_type;

   // Walk state of one line, loaded by a start transfer
   typedef struct packed {
      logic      steep;
      coord_type major_pos;
      coord_type major_end;
      coord_type minor_pos;
      logic      step_down;
      err_type   error;
      delta_type major_delta;
      delta_type minor_delta;
      color_type color;
   } line_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      on_screen;
      logic      last;
   } pixel_type;

endpackage

>>> hdl/bres_ifs.sv
// Request and response channel interfaces of the line rasterizer.
interface bres_req_if;
   import bres_pkg::*;

   logic      valid;
   logic      ready;
   logic      func;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   color_type line_color;

   modport source (output valid, func, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink (input valid, func, start_x, start_y, end_x, end_y, line_color,
                 output ready);
endinterface

interface bres_rsp_if;
   import bres_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   color_type pixel_color;
   logic      on_screen;
   logic      last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
                 output ready);
endinterface

>>> hdl/bres_setup.sv
// Line setup: steep test, endpoint ordering and initial error term.
module bres_setup
   import bres_pkg::*;
(
   input  coord_type start_x,
   input  coord_type start_y,
   input  coord_type end_x,
   input  coord_type end_y,
   input  color_type line_color,
   output line_type  line
);

   sdelta_type dx;
   sdelta_type dy;
   delta_type  abs_dx;
   delta_type  abs_dy;
   logic       steep;
   coord_type  a0;
   coord_type  a1;
   coord_type  b0;
   coord_type  b1;
   coord_type  maj_lo;
   coord_type  maj_hi;
   coord_type  min_lo;
   coord_type  min_hi;
   logic       swap;
   delta_type  major_delta;
   sdelta_type minor_diff;

   always_comb begin
      dx     = sdelta_type'(end_x) - sdelta_type'(start_x);
      dy     = sdelta_type'(end_y) - sdelta_type'(start_y);
      abs_dx = dx[DELTA_BITS-1] ? delta_type'(-dx) : delta_type'(dx);
      abs_dy = dy[DELTA_BITS-1] ? delta_type'(-dy) : delta_type'(dy);
      steep  = abs_dy > abs_dx;

      a0 = steep ? start_y : start_x;
      b0 = steep ? start_x : start_y;
      a1 = steep ? end_y   : end_x;
      b1 = steep ? end_x   : end_y;

      // draw from the lower major coordinate upward
      swap   = a0 > a1;
      maj_lo = swap ? a1 : a0;
      maj_hi = swap ? a0 : a1;
      min_lo = swap ? b1 : b0;
      min_hi = swap ? b0 : b1;

      major_delta = delta_type'(sdelta_type'(maj_hi) - sdelta_type'(maj_lo));
      minor_diff  = sdelta_type'(min_hi) - sdelta_type'(min_lo);

      line.steep       = steep;
      line.major_pos   = maj_lo;
      line.major_end   = maj_hi;
      line.minor_pos   = min_lo;
      line.step_down   = !(min_lo < min_hi);
      line.error       = err_type'({1'b0, major_delta[DELTA_BITS-1:1]});
      line.major_delta = major_delta;
      line.minor_delta = minor_diff[DELTA_BITS-1] ? delta_type'(-minor_diff)
                                                  : delta_type'(minor_diff);
      line.color       = line_color;
   end

endmodule

>>> hdl/bres_stepper.sv
// Line walk state and the per-pixel Bresenham step with the on-screen test.
module bres_stepper
   import bres_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       func,
   input  line_type   setup_line,
   input  screen_type screen_width,
   input  screen_type screen_height,
   output logic       pix_valid,
   output pixel_type  pix
);

   logic     busy_ff;
   logic     busy_in;
   line_type line_ff;
   line_type line_in;

   logic      last;
   err_type   err_sub;
   err_type   err_fix;
   coord_type minor_inc;
   coord_type px;
   coord_type py;
   logic      x_in;
   logic      y_in;

   always_comb begin
      px   = line_ff.steep ? line_ff.minor_pos : line_ff.major_pos;
      py   = line_ff.steep ? line_ff.major_pos : line_ff.minor_pos;
      last = line_ff.major_pos >= line_ff.major_end;

      x_in = !px[COORD_BITS-1] &&
             (px[COORD_BITS-2:0] < (COORD_BITS-1)'(screen_width));
      y_in = !py[COORD_BITS-1] &&
             (py[COORD_BITS-2:0] < (COORD_BITS-1)'(screen_height));

      pix_valid     = accept && (func == FUNC_STEP) && busy_ff;
      pix.x         = px;
      pix.y         = py;
      pix.color     = line_ff.color;
      pix.on_screen = x_in && y_in;
      pix.last      = last;

      err_sub   = line_ff.error - err_type'({1'b0, line_ff.minor_delta});
      err_fix   = err_sub + err_type'({1'b0, line_ff.major_delta});
      minor_inc = line_ff.step_down ? {COORD_BITS{1'b1}} : coord_type'(1);

      busy_in = busy_ff;
      line_in = line_ff;
      if (accept && (func == FUNC_START)) begin
         busy_in = 1'b1;
         line_in = setup_line;
      end else if (pix_valid) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            line_in.major_pos = line_ff.major_pos + coord_type'(1);
            if (err_sub[ERR_BITS-1]) begin
               line_in.minor_pos = line_ff.minor_pos + minor_inc;
               line_in.error     = err_fix;
            end else begin
               line_in.error = err_sub;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         line_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         line_ff <= line_in;
      end
   end

endmodule

>>> hdl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: a start transfer (func 0) loads two endpoints and a
// color and gives no response; each step transfer (func 1) then gives one pixel,
// from the lower major coordinate upward, with an on-screen flag against the
// screen_width/screen_height registers and last_pixel on the final one. Steps
// while no line is active give nothing, and a start abandons any line in
// progress. The line state sits in registers and one pixel step (subtract, sign
// test, add) feeds the response register, so a new request is taken every clock
// as long as the response is drained. The user writes registers through csr_*
// only while no request is outstanding; the block itself does not enforce it.
module bresenham_line_rasterizer
   import bres_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   bres_req_if.sink                  req_ch,
   bres_rsp_if.source                rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   screen_type width_ff;
   screen_type height_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   pixel_type  rsp_ff;
   pixel_type  rsp_in;

   logic      accept;
   line_type  setup_line;
   logic      pix_valid;
   pixel_type pix;

   // response register empties or drains this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   bres_setup u_setup (
      .start_x    (req_ch.start_x),
      .start_y    (req_ch.start_y),
      .end_x      (req_ch.end_x),
      .end_y      (req_ch.end_y),
      .line_color (req_ch.line_color),
      .line       (setup_line)
   );

   bres_stepper u_stepper (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .func          (req_ch.func),
      .setup_line    (setup_line),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .pix_valid     (pix_valid),
      .pix           (pix)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (pix_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         width_ff     <= SCREEN_WIDTH_RESET;
         height_ff    <= SCREEN_HEIGHT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_x     = rsp_ff.x;
   assign rsp_ch.pixel_y     = rsp_ff.y;
   assign rsp_ch.pixel_color = rsp_ff.color;
   assign rsp_ch.on_screen   = rsp_ff.on_screen;
   assign rsp_ch.last_pixel  = rsp_ff.last;

endmodule

>>> hdl/bres_checker.sv
// Port-level checks of the line rasterizer, bound to the top level.
module bres_checker
   import bres_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      req_func,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type rsp_pix
);

   // a stalled response keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pix))
      else $error("stalled response changed");

   // requests are only held off by a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // a start transfer never produces a pixel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_START) && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("start transfer produced a response");

   // on-screen pixels have non-negative coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pix.on_screen |-> !rsp_pix.x[COORD_BITS-1] && !rsp_pix.y[COORD_BITS-1])
      else $error("negative coordinate flagged on screen");

endmodule

bind bresenham_line_rasterizer bres_checker u_bres_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_func  (req_ch.func),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pix   ({rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.pixel_color,
                rsp_ch.on_screen, rsp_ch.last_pixel})
);
